// ===== rtl/jmd_pkg.sv =====
package jmd_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV_MAG,
      ST_DIV_K,
      ST_MUL_G,
      ST_MUL_K,
      ST_DIV_D,
      ST_OUT
   } state_type;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_H_CENTER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_V_CENTER   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_DIV  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_INTV   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCR_INTV   = 3'd7;
   localparam int CSR_DATA_W = 16;

   localparam int DELTA_W = 8;
   localparam int MAG_W   = 7;
   localparam int GAIN_W  = 8;
   localparam int INTV_W  = 16;
   localparam int QUO_W   = 8;                    // one overflow bit + 7 result bits
   localparam int STEP_W  = 3;
   localparam int PROD1_W = MAG_W + GAIN_W;       // mag * gain
   localparam int PROD_W  = PROD1_W + MAG_W;      // mag * gain * k

   localparam logic [MAG_W-1:0] SCALE = 7'd127;   // full-scale magnitude

   localparam logic [GAIN_W-1:0] GAIN_RST = 8'd1;
   localparam logic [GAIN_W-1:0] DIV_RST  = 8'd15;
   localparam logic [INTV_W-1:0] CUR_RST  = 16'd10;
   localparam logic [INTV_W-1:0] SCR_RST  = 16'd100;

   localparam logic [DELTA_W-1:0] DELTA_POS_SAT = 8'h7f;
   localparam logic [DELTA_W-1:0] DELTA_NEG_SAT = 8'h80;

endpackage

// ===== rtl/joystick_to_mouse_delta.sv =====
// channel  | dir | tdata (low bit up)                              | tuser
// ---------+-----+-------------------------------------------------+--------------
// req_     | in  | horizontal_sample, vertical_sample, button_level| scroll_mode
// rsp_     | out | move_x, move_y, scroll_h, scroll_v,              | updated
//          |     | button_pressed                                   |
// csr_     | in  | write enable, index 0..7, 16-bit data           | -
//
// A tick that does not reach its interval is answered in the cycle after its beat.
// A tick that fires passes per axis through a setup state, three 8-step
// restoring divisions on one shared bit-serial divider and the multiply states
// ST_MUL_G and ST_MUL_K (an axis at rest or on an empty side takes only the setup).
// Synchronous reset loads the register defaults and clears the tick counter.
// One tick is in work at a time; req_tready drops while the sequencer runs or
// while a result waits on rsp_tready.
module joystick_to_mouse_delta #(
   parameter int SAMPLE_BITS = 10,
   localparam int REQ_W = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // horizontal_sample, vertical_sample, button_level, zero fill
   input  logic [REQ_W-1:0]                req_tdata,
   // scroll_mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // move_x, move_y, scroll_h, scroll_v, button_pressed, zero fill
   output logic [39:0]                     rsp_tdata,
   // updated
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [jmd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [jmd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int NUM_W = (SB + 7 > jmd_pkg::PROD_W) ? SB + 7 : jmd_pkg::PROD_W;
   localparam int DW    = jmd_pkg::DELTA_W;

   // configuration
   logic [SB-1:0]                   axis_min_ff, axis_max_ff, h_center_ff, v_center_ff;
   logic [jmd_pkg::GAIN_W-1:0]      gain_ff, div_ff;
   logic [jmd_pkg::INTV_W-1:0]      cur_intv_ff, scr_intv_ff;

   // control
   jmd_pkg::state_type              state_ff, state_in;
   logic [jmd_pkg::INTV_W-1:0]      ticks_ff, ticks_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SB-1:0]                   hs_ff, hs_in, vs_ff, vs_in;
   logic                            scroll_ff, scroll_in, button_ff, button_in;
   logic                            axis_ff, axis_in, neg_ff, neg_in;
   logic [NUM_W-1:0]                rem_ff, rem_in, dsh_ff, dsh_in;
   logic [jmd_pkg::QUO_W-1:0]       quo_ff, quo_in;
   logic [jmd_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [jmd_pkg::MAG_W-1:0]       mag_ff, mag_in, k_ff, k_in;
   logic [jmd_pkg::PROD1_W-1:0]     prod_ff, prod_in;
   logic [DW-1:0]                   dh_ff, dh_in, dv_ff, dv_in;
   logic                            upd_ff, upd_in, btn_out_ff, btn_out_in;
   logic [DW-1:0]                   mx_ff, mx_in, my_ff, my_in, sh_ff, sh_in, sv_ff, sv_in;

   // combinational helpers
   logic                            req_fire;
   logic [jmd_pkg::INTV_W-1:0]      cnt_next, intv_sel;
   logic                            tick_fire;
   logic [SB-1:0]                   smp, ctr, offs, span;
   logic                            side_lo, side_empty;
   logic                            div_ge;
   logic [NUM_W-1:0]                rem_sub;
   logic [jmd_pkg::QUO_W-1:0]       quo_nx;
   logic [jmd_pkg::GAIN_W-1:0]      div_eff;
   logic [DW-1:0]                   delta;
   logic [DW-1:0]                   dmag;

   assign req_tready = (state_ff == jmd_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign cnt_next  = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
   assign intv_sel  = req_tuser ? scr_intv_ff : cur_intv_ff;
   assign tick_fire = cnt_next > intv_sel;

   // axis setup
   assign smp        = axis_ff ? vs_ff : hs_ff;
   assign ctr        = axis_ff ? v_center_ff : h_center_ff;
   assign side_lo    = smp < ctr;
   assign side_empty = (smp == ctr) ||
                       (side_lo ? (ctr <= axis_min_ff) : (axis_max_ff <= ctr));
   assign offs       = side_lo ? ctr - smp : smp - ctr;
   assign span       = side_lo ? ctr - axis_min_ff : axis_max_ff - ctr;

   // one restoring step; dsh holds the divisor aligned to the current bit
   assign div_ge  = rem_ff >= dsh_ff;
   assign rem_sub = rem_ff - dsh_ff;
   assign quo_nx  = {quo_ff[jmd_pkg::QUO_W-2:0], div_ge};

   assign div_eff = (div_ff == '0) ? 8'd1 : div_ff;

   // final delta: top quotient bit means the quotient reached 128
   assign dmag = {1'b0, quo_nx[jmd_pkg::MAG_W-1:0]};
   always_comb begin
      if (neg_ff) begin
         delta = quo_nx[jmd_pkg::QUO_W-1] ? jmd_pkg::DELTA_NEG_SAT : DW'(8'd0 - dmag);
      end else begin
         delta = quo_nx[jmd_pkg::QUO_W-1] ? jmd_pkg::DELTA_POS_SAT : dmag;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ticks_in     = ticks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hs_in        = hs_ff;
      vs_in        = vs_ff;
      scroll_in    = scroll_ff;
      button_in    = button_ff;
      axis_in      = axis_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      mag_in       = mag_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      dh_in        = dh_ff;
      dv_in        = dv_ff;
      upd_in       = upd_ff;
      btn_out_in   = btn_out_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      sh_in        = sh_ff;
      sv_in        = sv_ff;

      case (state_ff)
         jmd_pkg::ST_IDLE: begin
            if (req_fire) begin
               hs_in     = req_tdata[SB-1:0];
               vs_in     = req_tdata[2*SB-1:SB];
               button_in = req_tdata[2*SB];
               scroll_in = req_tuser;
               if (tick_fire) begin
                  ticks_in = '0;
                  axis_in  = 1'b0;
                  state_in = jmd_pkg::ST_SETUP;
               end else begin
                  ticks_in     = cnt_next;
                  rsp_valid_in = 1'b1;
                  upd_in       = 1'b0;
                  btn_out_in   = ~req_tdata[2*SB];
                  mx_in        = '0;
                  my_in        = '0;
                  sh_in        = '0;
                  sv_in        = '0;
               end
            end
         end
         jmd_pkg::ST_SETUP: begin
            neg_in  = side_lo;
            rem_in  = (NUM_W'(offs) << 7) - NUM_W'(offs);   // 127 * offs
            dsh_in  = NUM_W'(span) << 7;
            quo_in  = '0;
            step_in = '1;
            if (side_empty) begin
               if (!axis_ff) begin
                  dh_in   = '0;
                  axis_in = 1'b1;
               end else begin
                  dv_in    = '0;
                  state_in = jmd_pkg::ST_OUT;
               end
            end else begin
               state_in = jmd_pkg::ST_DIV_MAG;
            end
         end
         jmd_pkg::ST_DIV_MAG, jmd_pkg::ST_DIV_K, jmd_pkg::ST_DIV_D: begin
            rem_in  = div_ge ? rem_sub : rem_ff;
            dsh_in  = dsh_ff >> 1;
            quo_in  = quo_nx;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               case (state_ff)
                  jmd_pkg::ST_DIV_MAG: begin
                     mag_in   = quo_nx[jmd_pkg::QUO_W-1] ? jmd_pkg::SCALE
                                                         : quo_nx[jmd_pkg::MAG_W-1:0];
                     rem_in   = NUM_W'(quo_nx[jmd_pkg::QUO_W-1] ? jmd_pkg::SCALE
                                                         : quo_nx[jmd_pkg::MAG_W-1:0]);
                     dsh_in   = NUM_W'(div_eff) << 7;
                     quo_in   = '0;
                     state_in = jmd_pkg::ST_DIV_K;
                  end
                  jmd_pkg::ST_DIV_K: begin
                     k_in     = quo_nx[jmd_pkg::MAG_W-1:0];
                     state_in = jmd_pkg::ST_MUL_G;
                  end
                  default: begin
                     if (!axis_ff) begin
                        dh_in    = delta;
                        axis_in  = 1'b1;
                        state_in = jmd_pkg::ST_SETUP;
                     end else begin
                        dv_in    = delta;
                        state_in = jmd_pkg::ST_OUT;
                     end
                  end
               endcase
            end
         end
         jmd_pkg::ST_MUL_G: begin
            prod_in  = jmd_pkg::PROD1_W'(mag_ff) * jmd_pkg::PROD1_W'(gain_ff);
            state_in = jmd_pkg::ST_MUL_K;
         end
         jmd_pkg::ST_MUL_K: begin
            rem_in   = NUM_W'(jmd_pkg::PROD_W'(prod_ff) * jmd_pkg::PROD_W'(k_ff));
            dsh_in   = NUM_W'(jmd_pkg::SCALE) << 7;
            quo_in   = '0;
            step_in  = '1;
            state_in = jmd_pkg::ST_DIV_D;
         end
         jmd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               upd_in       = 1'b1;
               btn_out_in   = ~button_ff;
               mx_in        = scroll_ff ? '0 : dh_ff;
               my_in        = scroll_ff ? '0 : dv_ff;
               sh_in        = scroll_ff ? dh_ff : '0;
               sv_in        = scroll_ff ? dv_ff : '0;
               state_in     = jmd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jmd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jmd_pkg::ST_IDLE;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_min_ff <= SB'(190);
         axis_max_ff <= SB'(840);
         h_center_ff <= SB'(512);
         v_center_ff <= SB'(512);
         gain_ff     <= jmd_pkg::GAIN_RST;
         div_ff      <= jmd_pkg::DIV_RST;
         cur_intv_ff <= jmd_pkg::CUR_RST;
         scr_intv_ff <= jmd_pkg::SCR_RST;
      end else if (csr_we) begin
         case (csr_index)
            jmd_pkg::CSR_AXIS_MIN:   axis_min_ff <= csr_wdata[SB-1:0];
            jmd_pkg::CSR_AXIS_MAX:   axis_max_ff <= csr_wdata[SB-1:0];
            jmd_pkg::CSR_H_CENTER:   h_center_ff <= csr_wdata[SB-1:0];
            jmd_pkg::CSR_V_CENTER:   v_center_ff <= csr_wdata[SB-1:0];
            jmd_pkg::CSR_SPEED_GAIN: gain_ff     <= csr_wdata[jmd_pkg::GAIN_W-1:0];
            jmd_pkg::CSR_SPEED_DIV:  div_ff      <= csr_wdata[jmd_pkg::GAIN_W-1:0];
            jmd_pkg::CSR_CUR_INTV:   cur_intv_ff <= csr_wdata[jmd_pkg::INTV_W-1:0];
            jmd_pkg::CSR_SCR_INTV:   scr_intv_ff <= csr_wdata[jmd_pkg::INTV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hs_ff      <= hs_in;
      vs_ff      <= vs_in;
      scroll_ff  <= scroll_in;
      button_ff  <= button_in;
      axis_ff    <= axis_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      mag_ff     <= mag_in;
      k_ff       <= k_in;
      prod_ff    <= prod_in;
      dh_ff      <= dh_in;
      dv_ff      <= dv_in;
      upd_ff     <= upd_in;
      btn_out_ff <= btn_out_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      sh_ff      <= sh_in;
      sv_ff      <= sv_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = upd_ff;
   assign rsp_tdata  = {7'b0, btn_out_ff, sv_ff, sh_ff, my_ff, mx_ff};

   // a tick that did not fire gives all-zero deltas
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] == '0)
      else $error("deltas nonzero on a tick without update");

   // only one of the cursor and scroll pairs carries data
   a_one_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] == '0) || (rsp_tdata[31:16] == '0))
      else $error("cursor and scroll deltas both nonzero");

   // firing clears the tick counter
   a_fire_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && tick_fire |=> ticks_ff == '0 && state_ff == jmd_pkg::ST_SETUP)
      else $error("tick counter not cleared on update");

   // a non-firing beat is answered in the next cycle
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && !tick_fire |=> rsp_tvalid && !rsp_tuser)
      else $error("non-updating tick not answered at once");

endmodule
